[design/lrpa_pkg.sv]
// Shared constants, codes and the token type of the point to region association block.
`default_nettype none
package lrpa_pkg;
  localparam int MAX_BOXES = 16;
  localparam int FRAC_BITS = 16;
  localparam int YW        = 50;
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);
  localparam int BIDX_W    = $clog2(MAX_BOXES);
  localparam int NCOEF     = 12;

  typedef enum logic [1:0] {
    OP_LOAD_COEF = 2'd0,
    OP_LOAD_BOX  = 2'd1,
    OP_CLASSIFY  = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  localparam logic CFG_SHRINK = 1'b0;
  localparam logic CFG_ACTIVE = 1'b1;

  typedef struct packed {
    logic               valid;
    logic               ok;
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic [CNT_W-1:0]   limit;
    logic [CNT_W-1:0]   count;
    logic [BIDX_W-1:0]  hit;
  } tok_t;
endpackage
`default_nettype wire

[design/lidar_point_roi_association_core.sv]
// Lidar point to region association: projection, division and a chain of box cells.
// Matrix and box loads are taken only while the core is not busy and return no result.
// A classify transaction passes through projection, division, the box chain (one cell
// per box) and the output register before it is offered. A zero third value skips the
// division; the next item waits until the result is taken. Reset clears control, zeroes
// the active count, sets shrink to 6554; matrix and box table hold nothing until loaded.
`default_nettype none
module lidar_point_roi_association_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [3:0]         slot_i,
  input  wire logic signed [31:0] coefficient_i,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] point_z_i,
  input  wire logic signed [12:0] box_left_i,
  input  wire logic signed [12:0] box_top_i,
  input  wire logic [11:0]        box_width_i,
  input  wire logic [11:0]        box_height_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      pixel_u_o,
  output logic signed [15:0]      pixel_v_o,
  output logic                    projection_ok_o,
  output logic [4:0]              enclosing_count_o,
  output logic                    assigned_o,
  output logic [3:0]              box_index_o
);
  localparam int N = lrpa_pkg::MAX_BOXES;

  logic [15:0]                    shrink_q;
  logic [4:0]                     active_q;
  logic                           busy_q, out_valid_q, acc_in, proj_done, div_done;
  logic signed [lrpa_pkg::YW-1:0] y0, y1, y2;
  logic signed [15:0]             q0, q1;
  logic [lrpa_pkg::CNT_W-1:0]     limit;
  lrpa_pkg::op_e                  op;
  lrpa_pkg::tok_t                 head;
  lrpa_pkg::tok_t                 chain [N+1];
  logic signed [15:0]             u_q, v_q;
  logic                           ok_q;
  logic [lrpa_pkg::CNT_W-1:0]     cnt_q;
  logic [lrpa_pkg::BIDX_W-1:0]    hit_q;

  assign op         = lrpa_pkg::op_e'(op_i);
  assign in_stall_o = busy_q;
  assign acc_in     = in_valid_i && !busy_q;
  assign limit      = (active_q > 5'(N)) ? lrpa_pkg::CNT_W'(N) : lrpa_pkg::CNT_W'(active_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shrink_q <= 16'd6554;
      active_q <= 5'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lrpa_pkg::CFG_SHRINK: shrink_q <= cfg_data_i;
        default:              active_q <= cfg_data_i[4:0];
      endcase
    end
  end

  lrpa_proj u_proj (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .coef_we_i  (acc_in && (op == lrpa_pkg::OP_LOAD_COEF)),
    .coef_idx_i (slot_i),
    .coef_i     (coefficient_i),
    .start_i    (acc_in && (op == lrpa_pkg::OP_CLASSIFY)),
    .px_i       (point_x_i),
    .py_i       (point_y_i),
    .pz_i       (point_z_i),
    .done_o     (proj_done),
    .y0_o       (y0),
    .y1_o       (y1),
    .y2_o       (y2)
  );

  lrpa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (proj_done && (y2 != '0)),
    .n0_i    (y0),
    .n1_i    (y1),
    .d_i     (y2),
    .done_o  (div_done),
    .q0_o    (q0),
    .q1_o    (q1)
  );

  // A zero third value skips the divider and sends an empty token down the chain.
  always_comb begin
    head.valid = div_done || (proj_done && (y2 == '0));
    head.ok    = div_done;
    head.u     = div_done ? q0 : 16'sd0;
    head.v     = div_done ? q1 : 16'sd0;
    head.limit = limit;
    head.count = '0;
    head.hit   = '0;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < N; i++) begin : g_cell
    lrpa_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (lrpa_pkg::CNT_W'(i)),
      .we_i     (acc_in && (op == lrpa_pkg::OP_LOAD_BOX) && (32'(slot_i) == 32'(i))),
      .left_i   (box_left_i),
      .top_i    (box_top_i),
      .width_i  (box_width_i),
      .height_i (box_height_i),
      .shrink_i (shrink_q),
      .tok_i    (chain[i]),
      .tok_o    (chain[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc_in && (op == lrpa_pkg::OP_CLASSIFY)) begin
        busy_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        busy_q <= 1'b0;
      end
      if (chain[N].valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain[N].valid) begin
      u_q   <= chain[N].u;
      v_q   <= chain[N].v;
      ok_q  <= chain[N].ok;
      cnt_q <= chain[N].count;
      hit_q <= chain[N].hit;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pixel_u_o         = u_q;
  assign pixel_v_o         = v_q;
  assign projection_ok_o   = ok_q;
  assign enclosing_count_o = 5'(cnt_q);
  assign assigned_o        = (cnt_q == lrpa_pkg::CNT_W'(1));
  assign box_index_o       = (cnt_q == lrpa_pkg::CNT_W'(1)) ? 4'(hit_q) : 4'd0;
endmodule
`default_nettype wire

[design/lrpa_proj.sv]
// Projection unit: holds the 3x4 matrix and forms the three projected values with one multiplier.
`default_nettype none
module lrpa_proj (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          coef_we_i,
  input  wire logic [3:0]                    coef_idx_i,
  input  wire logic signed [31:0]            coef_i,
  input  wire logic                          start_i,
  input  wire logic signed [31:0]            px_i,
  input  wire logic signed [31:0]            py_i,
  input  wire logic signed [31:0]            pz_i,
  output logic                               done_o,
  output logic signed [lrpa_pkg::YW-1:0]     y0_o,
  output logic signed [lrpa_pkg::YW-1:0]     y1_o,
  output logic signed [lrpa_pkg::YW-1:0]     y2_o
);
  logic signed [31:0]             coef_q [lrpa_pkg::NCOEF];
  logic signed [lrpa_pkg::YW-1:0] acc_q [3];
  logic signed [31:0]             px_q, py_q, pz_q;
  logic signed [31:0]             coord_sel;
  logic signed [63:0]             mult_q;
  logic [1:0]                     row_q, col_q, mrow_q;
  logic                           busy_q, issue_q, mv_q, done_q;

  always_comb begin
    unique case (col_q)
      2'd0:    coord_sel = px_q;
      2'd1:    coord_sel = py_q;
      default: coord_sel = pz_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (coef_we_i && (coef_idx_i < 4'(lrpa_pkg::NCOEF))) begin
      coef_q[coef_idx_i] <= coef_i;
    end
    if (start_i) begin
      px_q <= px_i;
      py_q <= py_i;
      pz_q <= pz_i;
      acc_q[0] <= lrpa_pkg::YW'(coef_q[3]);
      acc_q[1] <= lrpa_pkg::YW'(coef_q[7]);
      acc_q[2] <= lrpa_pkg::YW'(coef_q[11]);
    end else if (mv_q) begin
      acc_q[mrow_q] <= acc_q[mrow_q] + lrpa_pkg::YW'(mult_q >>> lrpa_pkg::FRAC_BITS);
    end
    if (issue_q) begin
      mult_q <= coef_q[{row_q, col_q}] * coord_sel;
      mrow_q <= row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      issue_q <= 1'b0;
      mv_q    <= 1'b0;
      done_q  <= 1'b0;
      row_q   <= 2'd0;
      col_q   <= 2'd0;
    end else begin
      mv_q   <= issue_q;
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        issue_q <= 1'b1;
        row_q   <= 2'd0;
        col_q   <= 2'd0;
      end else if (issue_q) begin
        if (col_q == 2'd2) begin
          col_q <= 2'd0;
          row_q <= row_q + 2'd1;
          if (row_q == 2'd2) begin
            issue_q <= 1'b0;
          end
        end else begin
          col_q <= col_q + 2'd1;
        end
      end else if (busy_q && !mv_q) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign y0_o   = acc_q[0];
  assign y1_o   = acc_q[1];
  assign y2_o   = acc_q[2];
endmodule
`default_nettype wire

[design/lrpa_div.sv]
// Two-lane restoring divider that forms both pixel coordinates, truncated and saturated.
`default_nettype none
module lrpa_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [lrpa_pkg::YW-1:0] n0_i,
  input  wire logic signed [lrpa_pkg::YW-1:0] n1_i,
  input  wire logic signed [lrpa_pkg::YW-1:0] d_i,
  output logic                               done_o,
  output logic signed [15:0]                 q0_o,
  output logic signed [15:0]                 q1_o
);
  localparam int W  = lrpa_pkg::YW;
  localparam int CW = $clog2(W + 1);

  logic [W:0]    rem0_q, rem1_q, sh0, sh1;
  logic [W-1:0]  quo0_q, quo1_q, dm_q;
  logic          neg0_q, neg1_q, busy_q, done_q, ge0, ge1;
  logic [CW-1:0] cnt_q;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
    mag = a[W-1] ? W'(-a) : W'(a);
  endfunction

  function automatic logic signed [15:0] sat(input logic [W-1:0] q, input logic neg);
    if (!neg) begin
      sat = (q > W'(32767)) ? 16'sh7fff : q[15:0];
    end else begin
      sat = (q > W'(32768)) ? 16'sh8000 : (~q[15:0] + 16'd1);
    end
  endfunction

  assign sh0 = {rem0_q[W-1:0], quo0_q[W-1]};
  assign sh1 = {rem1_q[W-1:0], quo1_q[W-1]};
  assign ge0 = sh0 >= {1'b0, dm_q};
  assign ge1 = sh1 >= {1'b0, dm_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem0_q <= '0;
      rem1_q <= '0;
      quo0_q <= mag(n0_i);
      quo1_q <= mag(n1_i);
      dm_q   <= mag(d_i);
      neg0_q <= n0_i[W-1] ^ d_i[W-1];
      neg1_q <= n1_i[W-1] ^ d_i[W-1];
    end else if (busy_q) begin
      rem0_q <= ge0 ? (sh0 - {1'b0, dm_q}) : sh0;
      rem1_q <= ge1 ? (sh1 - {1'b0, dm_q}) : sh1;
      quo0_q <= {quo0_q[W-2:0], ge0};
      quo1_q <= {quo1_q[W-2:0], ge1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign q0_o   = sat(quo0_q, neg0_q);
  assign q1_o   = sat(quo1_q, neg1_q);
endmodule
`default_nettype wire

[design/lrpa_cell.sv]
// One box cell: stores a box entry, keeps its shrunk form and tests the passing point.
`default_nettype none
module lrpa_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [lrpa_pkg::CNT_W-1:0]  idx_i,
  input  wire logic                        we_i,
  input  wire logic signed [12:0]          left_i,
  input  wire logic signed [12:0]          top_i,
  input  wire logic [11:0]                 width_i,
  input  wire logic [11:0]                 height_i,
  input  wire logic [15:0]                 shrink_i,
  input  wire lrpa_pkg::tok_t              tok_i,
  output lrpa_pkg::tok_t                   tok_o
);
  logic signed [12:0]          left_q, top_q;
  logic [11:0]                 width_q, height_q;
  logic signed [16:0]          bx_q, by_q, bx_d, by_d;
  logic [12:0]                 bw_q, bh_q, bw_d, bh_d;
  logic signed [31:0]          numx, numy;
  logic [28:0]                 pw, ph;
  logic [16:0]                 keep;
  logic signed [16:0]          u17, v17;
  logic                        in_box;
  logic                        valid_q, ok_q;
  logic signed [15:0]          u_q, v_q;
  logic [lrpa_pkg::CNT_W-1:0]  limit_q, count_q;
  logic [lrpa_pkg::BIDX_W-1:0] hit_q;

  // Shrinking moves each edge in by half the fraction, rounded toward zero.
  always_comb begin
    keep = 17'h10000 - 17'(shrink_i);
    numx = (32'(left_q) <<< 17) + $signed({4'd0, 28'(shrink_i) * 28'(width_q)});
    numy = (32'(top_q) <<< 17) + $signed({4'd0, 28'(shrink_i) * 28'(height_q)});
    bx_d = 17'(numx[31] ? ((numx + 32'sd131071) >>> 17) : (numx >>> 17));
    by_d = 17'(numy[31] ? ((numy + 32'sd131071) >>> 17) : (numy >>> 17));
    pw   = 29'(width_q) * 29'(keep);
    ph   = 29'(height_q) * 29'(keep);
    bw_d = pw[28:16];
    bh_d = ph[28:16];
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      left_q   <= left_i;
      top_q    <= top_i;
      width_q  <= width_i;
      height_q <= height_i;
    end
    bx_q <= bx_d;
    by_q <= by_d;
    bw_q <= bw_d;
    bh_q <= bh_d;
  end

  assign u17 = 17'(tok_i.u);
  assign v17 = 17'(tok_i.v);
  assign in_box = tok_i.valid && tok_i.ok && (idx_i < tok_i.limit)
               && (u17 >= bx_q) && (u17 < bx_q + $signed({4'd0, bw_q}))
               && (v17 >= by_q) && (v17 < by_q + $signed({4'd0, bh_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q    <= tok_i.ok;
    u_q     <= tok_i.u;
    v_q     <= tok_i.v;
    limit_q <= tok_i.limit;
    count_q <= in_box ? (tok_i.count + lrpa_pkg::CNT_W'(1)) : tok_i.count;
    hit_q   <= in_box ? idx_i[lrpa_pkg::BIDX_W-1:0] : tok_i.hit;
  end

  always_comb begin
    tok_o.valid = valid_q;
    tok_o.ok    = ok_q;
    tok_o.u     = u_q;
    tok_o.v     = v_q;
    tok_o.limit = limit_q;
    tok_o.count = count_q;
    tok_o.hit   = hit_q;
  end
endmodule
`default_nettype wire

[bench/lidar_point_roi_association_core_tb.sv]
// Self-checking testbench for the lidar point to region association core.
`default_nettype none
module lidar_point_roi_association_core_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    lrpa_pkg::op_e      op;
    logic [3:0]         slot;
    logic signed [31:0] coefficient;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [12:0] left;
    logic signed [12:0] top;
    logic [11:0]        width;
    logic [11:0]        height;
  } point_item_t;

  typedef struct {
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic               ok;
    logic [4:0]         count;
    logic               assigned;
    logic [3:0]         index;
  } assoc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_idx = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  point_item_t cur = '{op: lrpa_pkg::OP_NONE, default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] pixel_u, pixel_v;
  logic projection_ok, assigned;
  logic [4:0] enclosing_count;
  logic [3:0] box_index;

  point_item_t   pending_items[$];
  assoc_result_t expected_results[$];
  int errors = 0;
  int cycle = 0;
  int max_gap = 0;
  int max_stall = 0;
  int gap_cnt = 0;
  int wait_cnt = 0;
  int hold_cnt = 0;

  // Predictor state.
  longint matrix[12];
  longint roi_left[16], roi_top[16], roi_width[16], roi_height[16];
  longint shrink = 6554;
  longint active = 0;

  always #1 clk = ~clk;

  lidar_point_roi_association_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(cur.op), .slot_i(cur.slot), .coefficient_i(cur.coefficient),
    .point_x_i(cur.px), .point_y_i(cur.py), .point_z_i(cur.pz),
    .box_left_i(cur.left), .box_top_i(cur.top),
    .box_width_i(cur.width), .box_height_i(cur.height),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pixel_u_o(pixel_u), .pixel_v_o(pixel_v), .projection_ok_o(projection_ok),
    .enclosing_count_o(enclosing_count), .assigned_o(assigned), .box_index_o(box_index)
  );

  task automatic add_item(point_item_t it);
    pending_items = {pending_items, it};
  endtask

  function automatic longint project_row(int r, point_item_t it);
    // Arithmetic shift of a signed product rounds toward minus infinity.
    return ((matrix[r*4] * longint'(it.px)) >>> lrpa_pkg::FRAC_BITS)
         + ((matrix[r*4+1] * longint'(it.py)) >>> lrpa_pkg::FRAC_BITS)
         + ((matrix[r*4+2] * longint'(it.pz)) >>> lrpa_pkg::FRAC_BITS)
         + matrix[r*4+3];
  endfunction

  function automatic longint sat16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  task automatic update_association(point_item_t it);
    assoc_result_t r;
    longint y0, y1, y2, u, v, bx, by, bw, bh, n, cnt, hit;
    if (it.op == lrpa_pkg::OP_LOAD_COEF) begin
      if (it.slot < lrpa_pkg::NCOEF) matrix[it.slot] = longint'(it.coefficient);
    end else if (it.op == lrpa_pkg::OP_LOAD_BOX) begin
      roi_left[it.slot] = longint'(it.left);
      roi_top[it.slot] = longint'(it.top);
      roi_width[it.slot] = longint'(it.width);
      roi_height[it.slot] = longint'(it.height);
    end else if (it.op == lrpa_pkg::OP_CLASSIFY) begin
      y0 = project_row(0, it);
      y1 = project_row(1, it);
      y2 = project_row(2, it);
      r = '{default: '0};
      if (y2 != 0) begin
        u = sat16(y0 / y2);
        v = sat16(y1 / y2);
        n = (active < lrpa_pkg::MAX_BOXES) ? active : lrpa_pkg::MAX_BOXES;
        cnt = 0;
        hit = 0;
        for (int i = 0; i < n; i++) begin
          bx = (roi_left[i] * 131072 + shrink * roi_width[i]) / 131072;
          by = (roi_top[i] * 131072 + shrink * roi_height[i]) / 131072;
          bw = (roi_width[i] * (65536 - shrink)) >>> 16;
          bh = (roi_height[i] * (65536 - shrink)) >>> 16;
          if (u >= bx && u < bx + bw && v >= by && v < by + bh) begin
            cnt++;
            hit = i;
          end
        end
        r.u = 16'(u);
        r.v = 16'(v);
        r.ok = 1'b1;
        r.count = 5'(cnt);
        r.assigned = (cnt == 1);
        r.index = (cnt == 1) ? 4'(hit) : 4'd0;
      end
      expected_results = {expected_results, r};
    end
  endtask

  // Driver: offers pending items, with a random gap after each transaction.
  always @(posedge clk) begin
    logic accepted;
    accepted = in_valid && !in_stall;
    if (accepted) begin
      update_association(cur);
      gap_cnt = $urandom_range(0, max_gap);
    end
    if (!in_valid || accepted) begin
      if (gap_cnt > 0) begin
        gap_cnt--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk) begin
    assoc_result_t e;
    if (out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no prediction pending");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (pixel_u !== e.u) begin
          $error("pixel_u expected %0d got %0d", e.u, pixel_u); errors++;
        end
        if (pixel_v !== e.v) begin
          $error("pixel_v expected %0d got %0d", e.v, pixel_v); errors++;
        end
        if (projection_ok !== e.ok) begin
          $error("projection_ok expected %0d got %0d", e.ok, projection_ok); errors++;
        end
        if (enclosing_count !== e.count) begin
          $error("enclosing_count expected %0d got %0d", e.count, enclosing_count); errors++;
        end
        if (assigned !== e.assigned) begin
          $error("assigned expected %0d got %0d", e.assigned, assigned); errors++;
        end
        if (box_index !== e.index) begin
          $error("box_index expected %0d got %0d", e.index, box_index); errors++;
        end
      end
      wait_cnt = $urandom_range(0, max_stall);
    end else if (wait_cnt > 0) begin
      wait_cnt--;
    end
    out_stall <= (wait_cnt > 0) || (hold_cnt > 0);
  end

  // Long receiver hold-off while the sender keeps offering points.
  always @(posedge clk) begin
    if (cycle == 2500) hold_cnt <= 600;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] plain_coef(int slot);
    // Unit scale on x and y and a constant third row, so pixels equal coordinates.
    if (slot == 0 || slot == 5) return 32'sd65536;
    if (slot == 11) return 32'sd1;
    return 32'sd0;
  endfunction

  function automatic point_item_t blank_item(lrpa_pkg::op_e op, int slot);
    point_item_t it;
    it = '{op: op, slot: 4'(slot), default: '0};
    return it;
  endfunction

  function automatic point_item_t point_at(longint x, longint y);
    point_item_t it;
    it = blank_item(lrpa_pkg::OP_CLASSIFY, 0);
    it.px = 32'(x);
    it.py = 32'(y);
    it.pz = $urandom;
    return it;
  endfunction

  function automatic point_item_t random_item();
    point_item_t it;
    int pick;
    it.slot = 4'($urandom);
    it.coefficient = $urandom;
    it.px = $urandom;
    it.py = $urandom;
    it.pz = $urandom;
    it.left = 13'($urandom);
    it.top = 13'($urandom);
    it.width = 12'($urandom);
    it.height = 12'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      it.op = lrpa_pkg::OP_CLASSIFY;
      if ($urandom_range(0, 9) < 7) begin
        it.px = $signed($urandom_range(0, 8400)) - 4200;
        it.py = $signed($urandom_range(0, 8400)) - 4200;
      end
    end else if (pick < 85) begin
      it.op = lrpa_pkg::OP_LOAD_BOX;
    end else if (pick < 96) begin
      it.op = lrpa_pkg::OP_LOAD_COEF;
      if ($urandom_range(0, 3) != 0) it.coefficient = plain_coef(int'(it.slot));
    end else begin
      it.op = lrpa_pkg::OP_NONE;
    end
    return it;
  endfunction

  task automatic write_reg(logic idx, logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lrpa_pkg::CFG_SHRINK) shrink = longint'(data);
    else active = longint'(data[4:0]);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || gap_cnt > 0 ||
           expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    point_item_t it;
    int shrink_set[6];
    int active_set[6];
    shrink_set = '{0, 65535, 6554, 32768, 1000, 50000};
    active_set = '{16, 16, 31, 0, 5, 17};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(lrpa_pkg::CFG_ACTIVE, 16'd16);

    // Directed part: full matrix and box table first, then edge points.
    for (int i = 0; i < lrpa_pkg::NCOEF; i++) begin
      it = blank_item(lrpa_pkg::OP_LOAD_COEF, i);
      it.coefficient = plain_coef(i);
      add_item(it);
    end
    for (int i = 0; i < 16; i++) begin
      it = blank_item(lrpa_pkg::OP_LOAD_BOX, i);
      it.left = 13'(i * 300 - 2400);
      it.top = 13'(i * 200 - 1600);
      it.width = 12'd400;
      it.height = 12'd300;
      if (i == 14) begin
        it.left = 13'sd4095; it.top = 13'sd4095; it.width = 12'd0; it.height = 12'd0;
      end
      if (i == 15) begin
        it.left = -13'sd4096; it.top = -13'sd4096; it.width = 12'd4095; it.height = 12'd4095;
      end
      add_item(it);
    end
    add_item(point_at(-2200, -1450));
    add_item(point_at(-1950, -1250));
    add_item(point_at(32'h7FFFFFFF, 32'h80000000));
    add_item(point_at(32'h80000000, 32'h7FFFFFFF));
    add_item(point_at(-4000, -4000));
    add_item(blank_item(lrpa_pkg::OP_NONE, 3));
    it = blank_item(lrpa_pkg::OP_LOAD_COEF, 12);
    it.coefficient = 32'h7FFFFFFF;
    add_item(it);
    // Third row all zero: the projection is flagged invalid.
    it = blank_item(lrpa_pkg::OP_LOAD_COEF, 11);
    add_item(it);
    add_item(point_at(100, 100));
    it.coefficient = 32'sd1;
    add_item(it);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(lrpa_pkg::CFG_SHRINK, 16'(shrink_set[ph]));
      write_reg(lrpa_pkg::CFG_ACTIVE, 16'(active_set[ph]));
      max_gap = (ph == 1) ? 0 : 16;
      max_stall = (ph == 1 || ph == 3) ? 0 : 16;
      for (int k = 0; k < 315; k++) add_item(random_item());
      wait_idle();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
